>>> src/grc_pkg.sv
// grc_pkg: shared constants, types and functions for grid_raycast_column.
// No dependencies.
package grc_pkg;

    localparam int MAP_W_DEF      = 16;
    localparam int MAP_H_DEF      = 16;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int FRAC_BITS      = 26;
    localparam int POS_W          = 34;   // signed Q.26 position, enough for far misses
    localparam int QW             = 6;    // queue entries

    localparam logic CFG_SCREEN_HEIGHT = 1'b0;
    localparam logic CFG_STEP_LENGTH   = 1'b1;

    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_WEST  = 2'd1;
    localparam logic [1:0] FACE_EAST  = 2'd2;
    localparam logic [1:0] FACE_SOUTH = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [3:0]  row_index;
        logic [15:0] row_walls;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic signed [15:0] vcos;
        logic signed [15:0] vsin;
        logic signed [15:0] rcos;
        logic signed [15:0] rsin;
        logic [7:0]  column;
    } grc_cmd_t;

    function automatic logic [14:0] quarter_sine(input logic [5:0] r);
        logic [14:0] v;
        begin
            unique case (r)
                6'd0: v = 15'd0;      6'd1: v = 15'd804;    6'd2: v = 15'd1606;
                6'd3: v = 15'd2404;   6'd4: v = 15'd3196;   6'd5: v = 15'd3981;
                6'd6: v = 15'd4756;   6'd7: v = 15'd5520;   6'd8: v = 15'd6270;
                6'd9: v = 15'd7005;   6'd10: v = 15'd7723;  6'd11: v = 15'd8423;
                6'd12: v = 15'd9102;  6'd13: v = 15'd9760;  6'd14: v = 15'd10394;
                6'd15: v = 15'd11003; 6'd16: v = 15'd11585; 6'd17: v = 15'd12140;
                6'd18: v = 15'd12665; 6'd19: v = 15'd13160; 6'd20: v = 15'd13623;
                6'd21: v = 15'd14053; 6'd22: v = 15'd14449; 6'd23: v = 15'd14811;
                6'd24: v = 15'd15137; 6'd25: v = 15'd15426; 6'd26: v = 15'd15679;
                6'd27: v = 15'd15893; 6'd28: v = 15'd16069; 6'd29: v = 15'd16207;
                6'd30: v = 15'd16305; 6'd31: v = 15'd16364; default: v = 15'd16384;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [15:0] sine_q14(input logic [15:0] a);
        logic [15:0] s;
        logic [6:0]  k;
        logic [4:0]  r;
        logic [15:0] q;
        begin
            s = a + 16'd256;
            k = s[15:9];
            r = k[4:0];
            unique case (k[6:5])
                2'd0: q = {1'b0, quarter_sine({1'b0, r})};
                2'd1: q = {1'b0, quarter_sine(6'd32 - {1'b0, r})};
                2'd2: q = -{1'b0, quarter_sine({1'b0, r})};
                default: q = -{1'b0, quarter_sine(6'd32 - {1'b0, r})};
            endcase
            return $signed(q);
        end
    endfunction

    function automatic logic [7:0] face_color(input logic [1:0] f);
        logic [7:0] c;
        begin
            unique case (f)
                FACE_NORTH: c = 8'd226;
                FACE_WEST:  c = 8'd21;
                FACE_EAST:  c = 8'd196;
                default:    c = 8'd208;
            endcase
            return c;
        end
    endfunction

endpackage

>>> src/grc_front.sv
// grc_front: accepts items, looks up sines and pushes commands into a queue.
// Depends on grc_pkg.
module grc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                stall,
    input  logic                kind,
    input  logic [3:0]          row_index,
    input  logic [15:0]         row_walls,
    input  logic [15:0]         pos_x,
    input  logic [15:0]         pos_y,
    input  logic [15:0]         view_angle,
    input  logic [15:0]         cast_angle,
    input  logic [7:0]          column,
    input  logic                pop,
    output logic                q_valid,
    output grc_pkg::grc_cmd_t   q_head
);
    localparam int AW = $clog2(grc_pkg::QW);
    grc_pkg::grc_cmd_t mem [grc_pkg::QW];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    grc_pkg::grc_cmd_t c;
    logic push;

    always_comb
    begin
        c.kind      = kind;
        c.row_index = row_index;
        c.row_walls = row_walls;
        c.pos_x     = pos_x;
        c.pos_y     = pos_y;
        c.vcos      = grc_pkg::sine_q14(view_angle + 16'd16384);
        c.vsin      = grc_pkg::sine_q14(view_angle);
        c.rcos      = grc_pkg::sine_q14(cast_angle + 16'd16384);
        c.rsin      = grc_pkg::sine_q14(cast_angle);
        c.column    = column;
    end

    assign stall   = (cnt_reg == (AW+1)'(grc_pkg::QW));
    assign push    = valid && !stall;
    assign q_valid = (cnt_reg != '0);
    assign q_head  = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem[wp_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= (wp_reg == AW'(grc_pkg::QW-1)) ? '0 : wp_reg + 1'b1;
            if (pop)  rp_reg <= (rp_reg == AW'(grc_pkg::QW-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

>>> src/grc_div.sv
// grc_div: restoring divider, one quotient bit per cycle.
// No package dependencies.
module grc_div #(
    parameter int NW = 40,
    parameter int DW = 40
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic          rem_nz
);
    localparam int CW = $clog2(NW+1);
    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] n_reg;
    logic          busy_reg;
    logic [DW:0]   sh;

    assign sh     = {r_reg[DW-1:0], q_reg[NW-1]};
    assign quo    = q_reg;
    assign rem_nz = (r_reg != '0);
    assign done   = busy_reg && (n_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; n_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1; n_reg <= CW'(NW);
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg)
            n_reg <= n_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num; r_reg <= '0; d_reg <= den;
        end
        else if (busy_reg && n_reg != '0)
        begin
            if (sh >= {1'b0, d_reg})
            begin
                r_reg <= sh - {1'b0, d_reg};
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= sh;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end
endmodule

>>> src/grc_back.sv
// grc_back: map store, ray march sequencer, projection and span math.
// Depends on grc_pkg and grc_div.
module grc_back #(
    parameter int MAP_W      = grc_pkg::MAP_W_DEF,
    parameter int MAP_H      = grc_pkg::MAP_H_DEF,
    parameter int MAX_HEIGHT = grc_pkg::MAX_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  grc_pkg::grc_cmd_t q_head,
    output logic              pop,
    input  logic [6:0]        screen_height,
    input  logic [11:0]       step_length,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        column_out,
    output logic [5:0]        wall_top,
    output logic [5:0]        wall_bottom,
    output logic [1:0]        face,
    output logic [7:0]        wall_color
);
    localparam int PW  = grc_pkg::POS_W;
    localparam int FB  = grc_pkg::FRAC_BITS;
    localparam int HW  = $clog2(MAX_HEIGHT+1);
    localparam int NW  = HW + 1 + FB;
    localparam int DW  = PW + 4;
    localparam int MA  = $clog2(MAP_H);

    localparam logic [2:0] S_IDLE = 3'd0, S_MARCH = 3'd1, S_PROJ = 3'd2,
                           S_PROJ2 = 3'd3, S_DIV = 3'd4, S_HI = 3'd5, S_OUT = 3'd6;

    logic [15:0] map_mem [MAP_H];
    logic [2:0]  st_reg;
    logic signed [PW-1:0] x_reg, y_reg, x0_reg, y0_reg;
    logic signed [PW-1:0] sx_reg, sy_reg;
    logic signed [15:0]   rc_reg, rs_reg, vc_reg, vs_reg;
    logic signed [PW+16:0] px_reg, py_reg;
    logic [7:0]  col_reg;
    logic [HW-1:0] h_reg;
    logic [1:0]  face_reg;
    logic [DW-1:0] d_reg;
    logic        dz_reg;
    logic [NW-1:0] lo_reg;
    logic [5:0]  top_reg, bot_reg;
    logic        ov_reg;
    logic [7:0]  ocol_reg;
    logic [5:0]  otop_reg, obot_reg;
    logic [1:0]  oface_reg;
    logic        emit;
    logic        wall;
    logic [HW-1:0] hcl;
    logic [MA-1:0] widx;

    // wall test on current position
    always_comb
    begin
        logic [PW-FB-1:0] cx, cy;
        logic [15:0] row;
        cx = x_reg[PW-1:FB];
        cy = y_reg[PW-1:FB];
        row = '0;
        if (x_reg < 0 || y_reg < 0)
            wall = 1'b1;
        else if (cx >= (PW-FB)'(MAP_W) || cy >= (PW-FB)'(MAP_H))
            wall = 1'b1;
        else
        begin
            row = map_mem[cy[MA-1:0]];
            wall = (cx < (PW-FB)'(16)) ? row[cx[3:0]] : 1'b0;
        end
    end

    always_comb
    begin
        if (screen_height == '0) hcl = HW'(1);
        else if ({25'd0, screen_height} > 32'(MAX_HEIGHT)) hcl = HW'(MAX_HEIGHT);
        else hcl = HW'(screen_height);
    end

    logic div_start, div_done, rem_nz;
    logic [NW-1:0] quo;
    logic [NW-1:0] num;
    assign num = NW'({h_reg, 1'b0}) << FB;

    grc_div #(.NW(NW), .DW(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(num), .den(d_reg),
        .done(div_done), .quo(quo), .rem_nz(rem_nz)
    );

    assign pop = (st_reg == S_IDLE) && q_valid;
    assign div_start = (st_reg == S_PROJ2) && !dz_reg;
    // result register takes the finished cast once it is free or draining
    assign emit = (st_reg == S_OUT) && (!ov_reg || !out_stall);

    assign out_valid   = ov_reg;
    assign column_out  = ocol_reg;
    assign wall_top    = otop_reg;
    assign wall_bottom = obot_reg;
    assign face        = oface_reg;
    assign wall_color  = grc_pkg::face_color(oface_reg);

    assign widx = MA'(q_head.row_index);

    always_ff @(posedge clk)
    begin
        if (pop && !q_head.kind && {28'd0, q_head.row_index} < 32'(MAP_H))
            map_mem[widx] <= q_head.row_walls;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ocol_reg  <= col_reg;
            otop_reg  <= top_reg;
            obot_reg  <= bot_reg;
            oface_reg <= face_reg;
        end
    end

    logic signed [PW+17:0] proj;
    logic [FB-1:0] fx, fy;
    logic [FB:0] ssx, ssy;
    logic [HW-1:0] ctr;
    logic [NW:0] hi;
    assign proj = (PW+18)'(px_reg) + (PW+18)'(py_reg);
    assign fx = x_reg[FB-1:0];
    assign fy = y_reg[FB-1:0];
    assign ssx = (rc_reg > 0) ? {1'b0, fx} : (FB+1)'(1 << FB) - {1'b0, fx};
    assign ssy = (rs_reg > 0) ? {1'b0, fy} : (FB+1)'(1 << FB) - {1'b0, fy};
    assign ctr = h_reg >> 1;
    assign hi  = {1'b0, lo_reg} + (NW+1)'(rem_nz);

    always_ff @(posedge clk)
    begin
        logic [11:0] stp;
        stp = (step_length == '0) ? 12'd1 : step_length;
        unique case (st_reg)
            S_IDLE:
            begin
                x_reg  <= PW'(q_head.pos_x) <<< 14;
                y_reg  <= PW'(q_head.pos_y) <<< 14;
                x0_reg <= PW'(q_head.pos_x) <<< 14;
                y0_reg <= PW'(q_head.pos_y) <<< 14;
                sx_reg <= PW'(q_head.rcos * $signed({1'b0, stp}));
                sy_reg <= PW'(q_head.rsin * $signed({1'b0, stp}));
                rc_reg <= q_head.rcos; rs_reg <= q_head.rsin;
                vc_reg <= q_head.vcos; vs_reg <= q_head.vsin;
                col_reg <= q_head.column;
                h_reg <= hcl;
            end
            S_MARCH:
                if (!wall)
                begin
                    x_reg <= x_reg + sx_reg;
                    y_reg <= y_reg + sy_reg;
                end
                else
                begin
                    if (ssx < ssy) face_reg <= (rc_reg > 0) ? grc_pkg::FACE_EAST : grc_pkg::FACE_WEST;
                    else face_reg <= (rs_reg > 0) ? grc_pkg::FACE_SOUTH : grc_pkg::FACE_NORTH;
                    px_reg <= (x_reg - x0_reg) * vc_reg;
                    py_reg <= (y_reg - y0_reg) * vs_reg;
                end
            S_PROJ:
            begin
                d_reg  <= (proj > 0) ? DW'(5 * (proj >>> 14)) : '0;
                dz_reg <= (proj <= 0) || ((proj >>> 14) == 0);
            end
            S_HI:
            begin
                top_reg <= (hi >= (NW+1)'(ctr)) ? 6'd0 : 6'(ctr - HW'(hi));
                bot_reg <= ((NW+1)'(ctr) + (NW+1)'(lo_reg) > (NW+1)'(h_reg - 1'b1)) ?
                           6'(h_reg - 1'b1) : 6'(ctr + HW'(lo_reg));
            end
            S_PROJ2:
                if (dz_reg)
                begin
                    top_reg <= 6'd0; bot_reg <= 6'(h_reg - 1'b1);
                end
            S_DIV: if (div_done) lo_reg <= quo;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; ov_reg <= 1'b0;
        end
        else
        begin
            if (emit) ov_reg <= 1'b1;
            else if (!out_stall) ov_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:  if (pop && q_head.kind) st_reg <= S_MARCH;
                S_MARCH: if (wall) st_reg <= S_PROJ;
                S_PROJ:  st_reg <= S_PROJ2;
                S_PROJ2: st_reg <= dz_reg ? S_OUT : S_DIV;
                S_DIV:   if (div_done) st_reg <= S_HI;
                S_HI:    st_reg <= S_OUT;
                S_OUT:   if (emit) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> src/grid_raycast_column.sv
// grid_raycast_column: top level, config registers, front queue and back engine.
// Depends on grc_pkg, grc_front, grc_back, grc_div.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | kind row_index row_walls pos_x pos_y angles column
//  out     | out_valid/out_stall| column_out wall_top wall_bottom face wall_color
//  cfg     | cfg_valid/cfg_ready| cfg_index cfg_data
//
// A cast of n march steps (about map diagonal / step_length steps) passes through
// the march, projection, bit-serial span division and span states in the back engine;
// a zero distance skips the division. Row writes are taken in the idle state of
// the back engine. A six-entry queue lets input transfers continue
// while the engine marches. Reset clears control state and loads the config
// registers with defaults; map rows hold nothing until written. out_stall holds
// the result register, then the engine waits with the next finished cast.
module grid_raycast_column #(
    parameter int MAP_W      = grc_pkg::MAP_W_DEF,
    parameter int MAP_H      = grc_pkg::MAP_H_DEF,
    parameter int MAX_HEIGHT = grc_pkg::MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [3:0]  row_index,
    input  logic [15:0] row_walls,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [15:0] view_angle,
    input  logic [15:0] cast_angle,
    input  logic [7:0]  column,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  column_out,
    output logic [5:0]  wall_top,
    output logic [5:0]  wall_bottom,
    output logic [1:0]  face,
    output logic [7:0]  wall_color,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);
    logic [6:0]  height_reg;
    logic [11:0] step_reg;
    logic q_valid, pop;
    grc_pkg::grc_cmd_t q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= 7'd24; step_reg <= 12'd205;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == grc_pkg::CFG_SCREEN_HEIGHT) height_reg <= cfg_data[6:0];
            else step_reg <= cfg_data;
        end
    end

    grc_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .stall(in_stall),
        .kind(kind), .row_index(row_index), .row_walls(row_walls),
        .pos_x(pos_x), .pos_y(pos_y), .view_angle(view_angle),
        .cast_angle(cast_angle), .column(column),
        .pop(pop), .q_valid(q_valid), .q_head(q_head)
    );

    grc_back #(.MAP_W(MAP_W), .MAP_H(MAP_H), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head), .pop(pop),
        .screen_height(height_reg), .step_length(step_reg),
        .out_valid(out_valid), .out_stall(out_stall), .column_out(column_out),
        .wall_top(wall_top), .wall_bottom(wall_bottom), .face(face),
        .wall_color(wall_color)
    );

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(column_out) && $stable(wall_top))
        else $error("result changed under stall");
    // span ordered
    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> wall_top <= wall_bottom)
        else $error("wall span inverted");
    // no pop from empty queue
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");
endmodule

>>> dv/grc_checker.sv
`timescale 1ns / 1ps
// grc_checker: predictor and scoreboard for grid_raycast_column.
// Watches the in, out and cfg channels; depends on grc_pkg for face codes.
module grc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic [3:0]  row_index,
    input  logic [15:0] row_walls,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [15:0] view_angle,
    input  logic [15:0] cast_angle,
    input  logic [7:0]  column,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  column_out,
    input  logic [5:0]  wall_top,
    input  logic [5:0]  wall_bottom,
    input  logic [1:0]  face,
    input  logic [7:0]  wall_color,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          spans_checked
);
    localparam longint ONE_CELL = 64'sd1 << 26;
    localparam int SINE_LUT[33] = '{
        0, 804, 1606, 2404, 3196, 3981, 4756, 5520, 6270, 7005, 7723,
        8423, 9102, 9760, 10394, 11003, 11585, 12140, 12665, 13160, 13623,
        14053, 14449, 14811, 15137, 15426, 15679, 15893, 16069, 16207, 16305,
        16364, 16384};

    typedef struct packed {
        logic [7:0] col;
        logic [5:0] top;
        logic [5:0] bot;
        logic [1:0] fc;
        logic [7:0] color;
    } span_t;

    logic [15:0] wall_map [16];
    int          height_reg;
    int          step_reg;
    span_t       span_q [$];

    assign pending = span_q.size();

    function automatic longint sin_q14(input logic [15:0] a);
        int k;
        int r;
        begin
            k = ((int'(a) + 256) >> 9) & 127;
            r = k & 31;
            case (k >> 5)
                0: return SINE_LUT[r];
                1: return SINE_LUT[32 - r];
                2: return -SINE_LUT[r];
                default: return -SINE_LUT[32 - r];
            endcase
        end
    endfunction

    function automatic longint cos_q14(input logic [15:0] a);
        return sin_q14(a + 16'd16384);
    endfunction

    function automatic bit in_wall(input longint x, input longint y);
        longint cx;
        longint cy;
        begin
            if (x < 0 || y < 0)
                return 1'b1;
            cx = x >>> 26;
            cy = y >>> 26;
            if (cx >= 16 || cy >= 16)
                return 1'b1;
            return wall_map[cy][cx];
        end
    endfunction

    function automatic span_t trace_span(input logic [15:0] px, input logic [15:0] py,
                                         input logic [15:0] va, input logic [15:0] ca,
                                         input logic [7:0] col);
        longint rc, rs, x0, y0, x, y, stp, fx, fy, sx, sy, proj, h, ctr;
        longint d, num, den, lo, hi, top, bot;
        span_t s;
        begin
            h = height_reg < 1 ? 1 : (height_reg > 64 ? 64 : height_reg);
            stp = step_reg == 0 ? 1 : step_reg;
            rc = cos_q14(ca);
            rs = sin_q14(ca);
            x0 = longint'(px) * 16384;
            y0 = longint'(py) * 16384;
            x = x0;
            y = y0;
            while (!in_wall(x, y)) begin
                x += rc * stp;
                y += rs * stp;
            end
            fx = x & (ONE_CELL - 1);
            fy = y & (ONE_CELL - 1);
            sx = rc > 0 ? fx : ONE_CELL - fx;
            sy = rs > 0 ? fy : ONE_CELL - fy;
            if (sx < sy)
                s.fc = rc > 0 ? grc_pkg::FACE_EAST : grc_pkg::FACE_WEST;
            else
                s.fc = rs > 0 ? grc_pkg::FACE_SOUTH : grc_pkg::FACE_NORTH;
            case (s.fc)
                grc_pkg::FACE_NORTH: s.color = 8'd226;
                grc_pkg::FACE_WEST:  s.color = 8'd21;
                grc_pkg::FACE_EAST:  s.color = 8'd196;
                default:             s.color = 8'd208;
            endcase
            // fisheye fix: project march vector on the view heading
            proj = (x - x0) * cos_q14(va) + (y - y0) * sin_q14(va);
            ctr = h / 2;
            top = 0;
            bot = h - 1;
            if (proj > 0) begin
                d = proj >>> 14;
                if (d != 0) begin
                    num = (h * 2) << 26;
                    den = d * 5;
                    lo = num / den;
                    hi = (num + den - 1) / den;
                    top = hi >= ctr ? 0 : ctr - hi;
                    bot = ctr + lo;
                    if (bot > h - 1)
                        bot = h - 1;
                end
            end
            s.col = col;
            s.top = top[5:0];
            s.bot = bot[5:0];
            return s;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        span_t e;
        if (!rst_n) begin
            height_reg = 24;
            step_reg = 205;
            errors = 0;
            spans_checked = 0;
            span_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == grc_pkg::CFG_SCREEN_HEIGHT)
                    height_reg = cfg_data[6:0];
                else
                    step_reg = cfg_data;
            end
            if (in_valid && !in_stall) begin
                if (!kind)
                    wall_map[row_index] = row_walls;
                else
                    span_q.push_back(trace_span(pos_x, pos_y, view_angle, cast_angle,
                                                column));
            end
            if (out_valid && !out_stall) begin
                spans_checked++;
                if (span_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result column_out=%0d", $time, column_out);
                end else begin
                    e = span_q.pop_front();
                    if (e.col !== column_out || e.top !== wall_top
                        || e.bot !== wall_bottom || e.fc !== face
                        || e.color !== wall_color) begin
                        errors++;
                        $display("%0t: mismatch exp col=%0d top=%0d bot=%0d face=%0d color=%0d",
                                 $time, e.col, e.top, e.bot, e.fc, e.color);
                        $display("%0t:          got col=%0d top=%0d bot=%0d face=%0d color=%0d",
                                 $time, column_out, wall_top, wall_bottom, face, wall_color);
                    end
                end
            end
        end
    end
endmodule

>>> dv/tb_grid_raycast_column.sv
`timescale 1ns / 1ps
// tb_grid_raycast_column: stimulus and verdict for grid_raycast_column.
// Depends on grc_pkg, the block and grc_checker (which predicts and compares).
module tb_grid_raycast_column;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [3:0]  row_index;
    logic [15:0] row_walls;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] view_angle;
    logic [15:0] cast_angle;
    logic [7:0]  column;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  column_out;
    logic [5:0]  wall_top;
    logic [5:0]  wall_bottom;
    logic [1:0]  face;
    logic [7:0]  wall_color;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [11:0] cfg_data;

    int errors;
    int pending;
    int spans_checked;

    // idle percentages for the two sides, and the long receiver hold-off request
    int src_idle_pct;
    int snk_idle_pct;
    bit hold_req;
    int hold_left;
    int transfers_in;
    int settings_seen;

    grid_raycast_column i_dut (.*);

    grc_checker i_checker (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver: random stall, plus one long hold-off on request.
    // With a six-entry queue in front of the engine this backs up into in_stall.
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_req = 1'b0;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < snk_idle_pct);
        end
    end

    // One transfer on the input channel. Idle cycles come first, so in_valid
    // gets a single assignment per clock edge.
    task automatic offer(input logic k, input logic [3:0] ri, input logic [15:0] rw,
                         input logic [15:0] px, input logic [15:0] py,
                         input logic [15:0] va, input logic [15:0] ca,
                         input logic [7:0] col);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        row_index  <= ri;
        row_walls  <= rw;
        pos_x      <= px;
        pos_y      <= py;
        view_angle <= va;
        cast_angle <= ca;
        column     <= col;
        do
            @(posedge clk);
        while (in_stall);
        transfers_in++;
    endtask

    task automatic load_row(input logic [3:0] ri, input logic [15:0] rw);
        offer(1'b0, ri, rw, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              8'($urandom));
    endtask

    task automatic cast(input logic [15:0] px, input logic [15:0] py,
                        input logic [15:0] va, input logic [15:0] ca, input logic [7:0] col);
        offer(1'b1, 4'($urandom), 16'($urandom), px, py, va, ca, col);
    endtask

    // Wait until every expected span is back, then give the engine time to
    // retire any trailing row write before touching the registers.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (64) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_view(input logic [11:0] h, input logic [11:0] stp);
        write_reg(grc_pkg::CFG_SCREEN_HEIGHT, h);
        write_reg(grc_pkg::CFG_STEP_LENGTH, stp);
        settings_seen++;
    endtask

    // Mostly casts near the view heading from inside the map; some wholly random
    // positions and headings (outside the map, behind the viewer), some row writes.
    task automatic random_items(input int n, input int hold_at);
        logic [15:0] va;
        logic [15:0] ca;
        logic [15:0] px;
        logic [15:0] py;
        for (int i = 0; i < n; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            if ($urandom_range(99) < 15)
            begin
                if ($urandom_range(1))
                    load_row(4'($urandom), 16'($urandom & $urandom));
                else
                    load_row(4'($urandom), 16'($urandom));
            end
            else
            begin
                va = 16'($urandom);
                ca = ($urandom_range(99) < 80)
                     ? 16'(va + $urandom_range(0, 16'h2000) - 16'h1000)
                     : 16'($urandom);
                px = ($urandom_range(3) != 0) ? 16'($urandom_range(16'h1000, 16'hEFFF))
                                              : 16'($urandom);
                py = ($urandom_range(3) != 0) ? 16'($urandom_range(16'h1000, 16'hEFFF))
                                              : 16'($urandom);
                cast(px, py, va, ca, 8'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = 1'b0;
        row_index = '0;
        row_walls = '0;
        pos_x = '0;
        pos_y = '0;
        view_angle = '0;
        cast_angle = '0;
        column = '0;
        cfg_valid = 1'b0;
        cfg_index = grc_pkg::CFG_SCREEN_HEIGHT;
        cfg_data = '0;
        hold_req = 1'b0;
        transfers_in = 0;
        settings_seen = 1;
        src_idle_pct = 29;
        snk_idle_pct = 45;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a bordered room with a few pillars, every map row defined
        // before the first cast.
        for (int r = 0; r < 16; r++)
            load_row(4'(r), (r == 0 || r == 15) ? 16'hFFFF : (r == 4 ? 16'h8421 : 16'h8001));
        cast(16'h8800, 16'h8800, 16'h0000, 16'h0000, 8'd0);      // east face
        cast(16'h8800, 16'h8800, 16'h4000, 16'h4000, 8'd1);      // south face
        cast(16'h8800, 16'h8800, 16'h8000, 16'h8000, 8'd2);      // west face
        cast(16'h8800, 16'h8800, 16'hC000, 16'hC000, 8'd3);      // north face
        cast(16'h8800, 16'h8800, 16'h8000, 16'h0000, 8'd4);      // looking away: full column
        cast(16'h0000, 16'h0000, 16'h0000, 16'h2000, 8'd5);      // starts in a wall
        cast(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);    // far corner, in the border wall
        cast(16'h1001, 16'hEFFF, 16'h6000, 16'hE000, 8'd170);    // diagonal toward corner
        cast(16'h5555, 16'hAAAA, 16'h3FFF, 16'h4100, 8'd85);     // oblique, just off due south
        drain();

        // receiver stalls more than the sender idles, with one pause until everything is back
        random_items(150, -1);
        drain();
        random_items(150, -1);
        drain();

        src_idle_pct = 45;
        snk_idle_pct = 29;
        set_view(12'd64, 12'd4095);
        random_items(300, -1);
        drain();

        // no idling; long receiver hold-off fills the queue
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_view(12'd1, 12'd820);
        random_items(300, 100);
        drain();

        // zero height and zero step: a solid map with one open cell keeps the
        // single-unit march to a few thousand steps
        for (int r = 0; r < 16; r++)
            load_row(4'(r), r == 8 ? 16'hFEFF : 16'hFFFF);
        drain();
        set_view(12'd0, 12'd0);
        for (int i = 0; i < 12; i++)
            cast({4'h8, 12'($urandom)}, {4'h8, 12'($urandom)}, 16'($urandom),
                 16'($urandom), 8'($urandom));
        drain();

        // widest height field and a large step over a fresh random map
        set_view(12'd127, 12'd2048);
        for (int r = 0; r < 16; r++)
            load_row(4'(r), 16'($urandom & $urandom));
        random_items(100, -1);
        drain();

        $display("run covered %0d input transfers and %0d checked spans over %0d settings",
                 transfers_in, spans_checked, settings_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("FAIL");
        $finish;
    end
endmodule
